FILE: design/tfsb_pkg.sv
// shared constants, command and status types and a helper function
// for the triangle fragment shade and blend unit; no dependencies
package tfsb_pkg;

    localparam int TEX_WIDTH  = 512;
    localparam int TEX_HEIGHT = 64;
    localparam int TEX_DEPTH  = 32768;
    localparam int TEX_AW     = 15;
    localparam int TXW        = 12;
    localparam int EW         = 35;
    localparam int MW         = 34;
    localparam int SW         = 52;
    localparam int DW         = 64;
    localparam int QW         = 14;
    localparam int CW         = 4;

    localparam logic [1:0] FUNC_VERTEX = 2'd0;
    localparam logic [1:0] FUNC_TEXEL  = 2'd1;
    localparam logic [1:0] FUNC_FRAG   = 2'd2;
    localparam logic [1:0] SLOT_SETUP  = 2'd2;

    localparam logic [2:0] CFG_CLIP_X_MIN = 3'd0;
    localparam logic [2:0] CFG_CLIP_Y_MIN = 3'd1;
    localparam logic [2:0] CFG_CLIP_X_MAX = 3'd2;
    localparam logic [2:0] CFG_CLIP_Y_MAX = 3'd3;
    localparam logic [2:0] CFG_SURF_W     = 3'd4;
    localparam logic [2:0] CFG_SURF_H     = 3'd5;
    localparam logic [2:0] CFG_TEXTURING  = 3'd6;

    localparam logic [2:0] TERM_R = 3'd0;
    localparam logic [2:0] TERM_A = 3'd3;
    localparam logic [2:0] TERM_U = 3'd4;
    localparam logic [2:0] TERM_V = 3'd5;

    localparam logic [1:0] SEL_AREA = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       area_go;
        logic       edge_go;
        logic [1:0] edge_sel;
        logic       sum_go;
        logic [2:0] term;
        logic       div_load;
        logic       div_step;
        logic       q_store;
        logic       tex_read;
        logic       alpha_go;
        logic       blend_go;
        logic       out_load;
        logic       out_write;
    } tfsb_cmd_t;

    typedef struct packed {
        logic frag_ok;
        logic in_tri;
        logic alpha_zero;
        logic texturing;
    } tfsb_stat_t;

    // exact v / 255 for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

endpackage

FILE: design/triangle_fragment_shade_blend_unit.sv
// fragment shade: vertex setup and area, inside test, interpolation, texture alpha, blend
// clipped fragments and fragments outside the triangle skip to the output unwritten;
// each color channel and texture coordinate (coordinates only with texturing) runs the
// shared 14-step divider once; one fragment in flight, the next request is taken the cycle
// after the result is loaded; a vertex or texel is taken in idle, the setup vertex also sets the area
// aresetn synchronous: config to reset values, vertices and area cleared, texture not
module triangle_fragment_shade_blend_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [1:0]         s_vertex_slot,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic [31:0]        s_vertex_rgba,
    input  logic [15:0]        s_vertex_u,
    input  logic [15:0]        s_vertex_v,
    input  logic [11:0]        s_frag_x,
    input  logic [11:0]        s_frag_y,
    input  logic [23:0]        s_dest_rgb,
    input  logic [14:0]        s_texel_address,
    input  logic [7:0]         s_texel_alpha,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_out_x,
    output logic [11:0]        m_out_y,
    output logic               m_write_pixel,
    output logic [23:0]        m_new_rgb,
    output logic               m_triangle_degenerate
);
    import tfsb_pkg::*;

    tfsb_cmd_t  cmd;
    tfsb_stat_t stat;

    tfsb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_vertex_slot (s_vertex_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    tfsb_datapath u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_func                (s_func),
        .s_vertex_slot         (s_vertex_slot),
        .s_vertex_x            (s_vertex_x),
        .s_vertex_y            (s_vertex_y),
        .s_vertex_rgba         (s_vertex_rgba),
        .s_vertex_u            (s_vertex_u),
        .s_vertex_v            (s_vertex_v),
        .s_frag_x              (s_frag_x),
        .s_frag_y              (s_frag_y),
        .s_dest_rgb            (s_dest_rgb),
        .s_texel_address       (s_texel_address),
        .s_texel_alpha         (s_texel_alpha),
        .cmd                   (cmd),
        .stat                  (stat),
        .m_out_x               (m_out_x),
        .m_out_y               (m_out_y),
        .m_write_pixel         (m_write_pixel),
        .m_new_rgb             (m_new_rgb),
        .m_triangle_degenerate (m_triangle_degenerate)
    );

    a_skip_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_pixel |-> m_new_rgb == 24'd0)
        else $error("skipped pixel carries color");

    a_degen_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_triangle_degenerate |-> !m_write_pixel)
        else $error("degenerate triangle wrote a pixel");

    a_frag_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_FRAG |=> !s_ready)
        else $error("fragment request did not occupy the unit");

endmodule

FILE: design/tfsb_ctrl.sv
// sequencer for the fragment unit: walks setup, edge, divide and blend steps
// depends on tfsb_pkg
module tfsb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [1:0]         s_vertex_slot,
    output logic               m_valid,
    input  logic               m_ready,
    input  tfsb_pkg::tfsb_stat_t stat,
    output tfsb_pkg::tfsb_cmd_t  cmd
);
    import tfsb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AREA, S_CHECK, S_EDGE, S_TEST, S_SUM, S_DLOAD, S_DIV,
        S_QSTORE, S_TEX, S_ALPHA, S_ACHK, S_BLEND, S_OUT_SKIP, S_OUT_WRITE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2:0]      term_reg;
    logic            m_valid_reg;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.accept    = (state_reg == S_IDLE) && s_valid;
        cmd.area_go   = (state_reg == S_AREA);
        cmd.edge_go   = (state_reg == S_EDGE);
        cmd.edge_sel  = cnt_reg[1:0];
        cmd.sum_go    = (state_reg == S_SUM);
        cmd.term      = term_reg;
        cmd.div_load  = (state_reg == S_DLOAD);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.q_store   = (state_reg == S_QSTORE);
        cmd.tex_read  = (state_reg == S_TEX);
        cmd.alpha_go  = (state_reg == S_ALPHA);
        cmd.blend_go  = (state_reg == S_BLEND);
        cmd.out_load  = ((state_reg == S_OUT_SKIP) || (state_reg == S_OUT_WRITE)) && out_free;
        cmd.out_write = (state_reg == S_OUT_WRITE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            term_reg    <= TERM_R;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_func == FUNC_VERTEX && s_vertex_slot == SLOT_SETUP) begin
                            state_reg <= S_AREA;
                        end else if (s_func == FUNC_FRAG) begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_AREA: state_reg <= S_IDLE;
                S_CHECK: begin
                    cnt_reg   <= '0;
                    state_reg <= stat.frag_ok ? S_EDGE : S_OUT_SKIP;
                end
                S_EDGE: begin
                    if (cnt_reg == CW'(2)) begin
                        state_reg <= S_TEST;
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_TEST: begin
                    term_reg  <= TERM_R;
                    state_reg <= stat.in_tri ? S_SUM : S_OUT_SKIP;
                end
                S_SUM: state_reg <= S_DLOAD;
                S_DLOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == CW'(QW - 1)) begin
                        state_reg <= S_QSTORE;
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_QSTORE: begin
                    if (term_reg == TERM_A && !stat.texturing) begin
                        state_reg <= S_ALPHA;
                    end else if (term_reg == TERM_V) begin
                        state_reg <= S_TEX;
                    end else begin
                        term_reg  <= term_reg + 3'd1;
                        state_reg <= S_SUM;
                    end
                end
                S_TEX:   state_reg <= S_ALPHA;
                S_ALPHA: state_reg <= S_ACHK;
                S_ACHK:  state_reg <= stat.alpha_zero ? S_OUT_SKIP : S_BLEND;
                S_BLEND: state_reg <= S_OUT_WRITE;
                S_OUT_SKIP, S_OUT_WRITE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/tfsb_datapath.sv
// datapath: vertex and config registers, edge unit, weighted sums,
// shared restoring divider, texture memory, blend and result register
// depends on tfsb_pkg
module tfsb_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_wdata,
    input  logic [1:0]           s_func,
    input  logic [1:0]           s_vertex_slot,
    input  logic signed [15:0]   s_vertex_x,
    input  logic signed [15:0]   s_vertex_y,
    input  logic [31:0]          s_vertex_rgba,
    input  logic [15:0]          s_vertex_u,
    input  logic [15:0]          s_vertex_v,
    input  logic [11:0]          s_frag_x,
    input  logic [11:0]          s_frag_y,
    input  logic [23:0]          s_dest_rgb,
    input  logic [14:0]          s_texel_address,
    input  logic [7:0]           s_texel_alpha,
    input  tfsb_pkg::tfsb_cmd_t  cmd,
    output tfsb_pkg::tfsb_stat_t stat,
    output logic [11:0]          m_out_x,
    output logic [11:0]          m_out_y,
    output logic                 m_write_pixel,
    output logic [23:0]          m_new_rgb,
    output logic                 m_triangle_degenerate
);
    import tfsb_pkg::*;

    logic [11:0] clip_x_min_reg, clip_y_min_reg, clip_x_max_reg, clip_y_max_reg;
    logic [12:0] surf_w_reg, surf_h_reg;
    logic        tex_on_reg;

    logic signed [15:0] vx_reg [3];
    logic signed [15:0] vy_reg [3];
    logic [31:0]        col_reg [3];
    logic [15:0]        u_reg [3];
    logic [15:0]        v_reg [3];
    logic signed [EW-1:0] area_reg;
    logic signed [EW-1:0] e_reg [3];

    logic [11:0] fx_reg, fy_reg;
    logic [23:0] dst_reg;

    logic [SW-1:0]  s_reg;
    logic [DW-1:0]  rem_reg, dsh_reg;
    logic [QW-1:0]  q_reg;
    logic [7:0]     src_reg [4];
    logic [TXW-1:0] tx_reg, ty_reg;
    logic [7:0]     tex_q_reg;
    logic [7:0]     alpha_reg;
    logic [15:0]    bl_reg [3];

    logic [7:0] tex_mem [TEX_DEPTH];

    // edge unit
    logic [1:0]         sel;
    logic signed [17:0] ax, ay, bx, by, cx, cy;
    logic signed [17:0] d1, d2, d3, d4;
    logic signed [35:0] p1, p2;
    logic signed [36:0] ev;

    assign sel = cmd.area_go ? SEL_AREA : cmd.edge_sel;

    always_comb begin
        ax = 18'(vx_reg[0]); ay = 18'(vy_reg[0]);
        bx = 18'(vx_reg[1]); by = 18'(vy_reg[1]);
        cx = $signed({2'b00, fx_reg, 4'h8});
        cy = $signed({2'b00, fy_reg, 4'h8});
        unique case (sel)
            2'd0: begin
                ax = 18'(vx_reg[1]); ay = 18'(vy_reg[1]);
                bx = 18'(vx_reg[2]); by = 18'(vy_reg[2]);
            end
            2'd1: begin
                ax = 18'(vx_reg[2]); ay = 18'(vy_reg[2]);
                bx = 18'(vx_reg[0]); by = 18'(vy_reg[0]);
            end
            2'd2: begin
            end
            default: begin
                cx = 18'(vx_reg[2]); cy = 18'(vy_reg[2]);
            end
        endcase
        d1 = cx - ax;
        d2 = by - ay;
        d3 = cy - ay;
        d4 = bx - ax;
        p1 = d1 * d2;
        p2 = d3 * d4;
        ev = 37'(p1) - 37'(p2);
    end

    // magnitudes
    logic [MW-1:0] em [3];
    logic [MW-1:0] am;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            em[k] = e_reg[k][EW-1] ? MW'(-e_reg[k]) : MW'(e_reg[k]);
        end
        am = area_reg[EW-1] ? MW'(-area_reg) : MW'(area_reg);
    end

    // weighted sum over the three vertices
    logic [15:0]   val [3];
    logic [SW-1:0] s_next;
    logic          tex_term;
    assign tex_term = (cmd.term == TERM_U) || (cmd.term == TERM_V);
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (cmd.term == TERM_U) begin
                val[k] = u_reg[k];
            end else if (cmd.term == TERM_V) begin
                val[k] = v_reg[k];
            end else begin
                val[k] = {8'd0, col_reg[k][8 * cmd.term[1:0] +: 8]};
            end
        end
        s_next = SW'(em[0]) * SW'(val[0]) + SW'(em[1]) * SW'(val[1])
               + SW'(em[2]) * SW'(val[2]);
    end

    // divider load and step
    logic [DW-1:0] d_init, v_init;
    logic          ge;
    always_comb begin
        if (cmd.term == TERM_U) begin
            d_init = DW'(s_reg) * DW'(TEX_WIDTH);
        end else if (cmd.term == TERM_V) begin
            d_init = DW'(s_reg) * DW'(TEX_HEIGHT);
        end else begin
            d_init = DW'(s_reg);
        end
        v_init = tex_term ? DW'({am, 16'd0}) : DW'(am);
        ge = rem_reg >= dsh_reg;
    end

    logic [TEX_AW-1:0] tex_idx;
    assign tex_idx = TEX_AW'(32'(ty_reg) * 32'(TEX_WIDTH) + 32'(tx_reg));

    // status
    logic all_pos, all_neg;
    always_comb begin
        all_pos = !e_reg[0][EW-1] && !e_reg[1][EW-1] && !e_reg[2][EW-1];
        all_neg = (e_reg[0][EW-1] || e_reg[0] == '0) && (e_reg[1][EW-1] || e_reg[1] == '0)
               && (e_reg[2][EW-1] || e_reg[2] == '0);
        stat.frag_ok = (area_reg != '0) && fx_reg >= clip_x_min_reg && fx_reg <= clip_x_max_reg
                    && fy_reg >= clip_y_min_reg && fy_reg <= clip_y_max_reg
                    && {1'b0, fx_reg} < surf_w_reg && {1'b0, fy_reg} < surf_h_reg;
        stat.in_tri     = area_reg[EW-1] ? all_neg : all_pos;
        stat.alpha_zero = (alpha_reg == 8'd0);
        stat.texturing  = tex_on_reg;
    end

    // config and triangle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_x_min_reg <= '0;
            clip_y_min_reg <= '0;
            clip_x_max_reg <= 12'hFFF;
            clip_y_max_reg <= 12'hFFF;
            surf_w_reg     <= 13'd4096;
            surf_h_reg     <= 13'd4096;
            tex_on_reg     <= 1'b0;
            area_reg       <= '0;
            for (int k = 0; k < 3; k++) begin
                vx_reg[k]  <= '0;
                vy_reg[k]  <= '0;
                col_reg[k] <= '0;
                u_reg[k]   <= '0;
                v_reg[k]   <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CLIP_X_MIN: clip_x_min_reg <= cfg_wdata[11:0];
                    CFG_CLIP_Y_MIN: clip_y_min_reg <= cfg_wdata[11:0];
                    CFG_CLIP_X_MAX: clip_x_max_reg <= cfg_wdata[11:0];
                    CFG_CLIP_Y_MAX: clip_y_max_reg <= cfg_wdata[11:0];
                    CFG_SURF_W:     surf_w_reg     <= cfg_wdata;
                    CFG_SURF_H:     surf_h_reg     <= cfg_wdata;
                    CFG_TEXTURING:  tex_on_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.accept && s_func == FUNC_VERTEX && s_vertex_slot <= SLOT_SETUP) begin
                vx_reg[s_vertex_slot]  <= s_vertex_x;
                vy_reg[s_vertex_slot]  <= s_vertex_y;
                col_reg[s_vertex_slot] <= s_vertex_rgba;
                u_reg[s_vertex_slot]   <= s_vertex_u;
                v_reg[s_vertex_slot]   <= s_vertex_v;
            end
            if (cmd.area_go) begin
                area_reg <= ev[EW-1:0];
            end
        end
    end

    // fragment working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_func == FUNC_FRAG) begin
            fx_reg  <= s_frag_x;
            fy_reg  <= s_frag_y;
            dst_reg <= s_dest_rgb;
        end
        if (cmd.edge_go) begin
            e_reg[cmd.edge_sel] <= ev[EW-1:0];
        end
        if (cmd.sum_go) begin
            s_reg <= s_next;
        end
        if (cmd.div_load) begin
            rem_reg <= d_init;
            dsh_reg <= v_init << (QW - 1);
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QW-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.q_store) begin
            if (cmd.term == TERM_U) begin
                tx_reg <= (q_reg >= QW'(TEX_WIDTH)) ? TXW'(TEX_WIDTH - 1) : TXW'(q_reg);
            end else if (cmd.term == TERM_V) begin
                ty_reg <= (q_reg >= QW'(TEX_HEIGHT)) ? TXW'(TEX_HEIGHT - 1) : TXW'(q_reg);
            end else begin
                src_reg[cmd.term[1:0]] <= (q_reg > QW'(255)) ? 8'hFF : q_reg[7:0];
            end
        end
        if (cmd.alpha_go) begin
            alpha_reg <= tex_on_reg ? div255({8'd0, src_reg[3]} * {8'd0, tex_q_reg})
                                    : src_reg[3];
        end
        if (cmd.blend_go) begin
            for (int k = 0; k < 3; k++) begin
                bl_reg[k] <= {8'd0, src_reg[k]} * {8'd0, alpha_reg}
                           + {8'd0, dst_reg[8 * (2 - k) +: 8]} * {8'd0, 8'hFF - alpha_reg};
            end
        end
    end

    // texture memory
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_func == FUNC_TEXEL) begin
            tex_mem[s_texel_address] <= s_texel_alpha;
        end
        if (cmd.tex_read) begin
            tex_q_reg <= tex_mem[tex_idx];
        end
    end

    // result register
    logic [23:0] rgb_next;
    always_comb begin
        if (!cmd.out_write) begin
            rgb_next = '0;
        end else if (alpha_reg == 8'hFF) begin
            rgb_next = {src_reg[0], src_reg[1], src_reg[2]};
        end else begin
            rgb_next = {div255(bl_reg[0]), div255(bl_reg[1]), div255(bl_reg[2])};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_out_x               <= fx_reg;
            m_out_y               <= fy_reg;
            m_write_pixel         <= cmd.out_write;
            m_new_rgb             <= rgb_next;
            m_triangle_degenerate <= (area_reg == '0);
        end
    end

endmodule
